### sv/vss_pkg.sv
`timescale 1ns / 1ps

package vss_pkg;

    localparam int AXIS_BITS = 6;
    localparam int ADDR_W    = 3 * AXIS_BITS;
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int COUNT_W   = ADDR_W + 1;
    localparam int SIZE_W    = 7;
    localparam int COORD_W   = 16;
    localparam int OUT_W     = 6;
    localparam int IDX_W     = 2;

    localparam logic [SIZE_W-1:0] AXIS_SPAN = SIZE_W'(1 << AXIS_BITS);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;

    localparam logic [2:0] STS_ADDED   = 3'd0;
    localparam logic [2:0] STS_PRESENT = 3'd1;
    localparam logic [2:0] STS_REMOVED = 3'd2;
    localparam logic [2:0] STS_ABSENT  = 3'd3;
    localparam logic [2:0] STS_OUTSIDE = 3'd4;
    localparam logic [2:0] STS_READ_OK = 3'd5;
    localparam logic [2:0] STS_BEYOND  = 3'd6;

    localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [ADDR_W-1:0]         position;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [OUT_W-1:0]   out_x;
        logic [OUT_W-1:0]   out_y;
        logic [OUT_W-1:0]   out_z;
        logic [COUNT_W-1:0] member_count;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC,
        ST_FIX
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic lookup;
        logic exec;
        logic fix;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_fix;
    } dp_status_t;

endpackage

### sv/vss_ctrl.sv
`timescale 1ns / 1ps

module vss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  vss_pkg::dp_status_t dp_status,
    output vss_pkg::ctrl_cmd_t  ctrl_cmd,
    output logic                busy
);
    import vss_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl_cmd.clear_step = 1'b1;
                if (dp_status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl_cmd.capture = 1'b1;
                    state_next       = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                ctrl_cmd.lookup = 1'b1;
                state_next      = ST_EXEC;
            end
            ST_EXEC:
            begin
                ctrl_cmd.exec = 1'b1;
                if (dp_status.need_fix)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    ctrl_cmd.finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_FIX:
            begin
                ctrl_cmd.fix    = 1'b1;
                ctrl_cmd.finish = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/vss_datapath.sv
`timescale 1ns / 1ps

module vss_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  vss_pkg::ctrl_cmd_t              ctrl_cmd,
    output vss_pkg::dp_status_t             dp_status,
    input  vss_pkg::item_t                  item,
    input  logic                            cfg_we,
    input  logic [vss_pkg::IDX_W-1:0]       cfg_index,
    input  logic [vss_pkg::SIZE_W-1:0]      cfg_data,
    output logic                            done,
    output vss_pkg::result_t                result
);
    import vss_pkg::*;

    // Map words hold list position plus one; zero marks an absent voxel.
    logic [COUNT_W-1:0] map_mem [DEPTH];
    logic [ADDR_W-1:0]  list_mem [DEPTH];

    logic [COUNT_W-1:0] map_q;
    logic [ADDR_W-1:0]  list_q;

    logic [SIZE_W-1:0]  size_x_reg;
    logic [SIZE_W-1:0]  size_y_reg;
    logic [SIZE_W-1:0]  size_z_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    item_t              item_reg;
    logic [ADDR_W-1:0]  fix_addr_reg;
    logic [COUNT_W-1:0] fix_data_reg;
    result_t            result_reg;
    result_t            result_next;
    logic               done_reg;

    logic               is_read;
    logic               in_volume;
    logic [ADDR_W-1:0]  voxel_addr;
    logic [COUNT_W-1:0] last;
    logic [COUNT_W-1:0] idx;
    logic               pos_ok;
    logic               del_hit;

    logic               map_we;
    logic [ADDR_W-1:0]  map_waddr;
    logic [COUNT_W-1:0] map_wdata;
    logic               list_we;
    logic [ADDR_W-1:0]  list_waddr;
    logic [ADDR_W-1:0]  list_wdata;
    logic [ADDR_W-1:0]  list_raddr;

    function automatic logic axis_ok(logic signed [COORD_W-1:0] c, logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] lim;
        lim = (size > AXIS_SPAN) ? AXIS_SPAN : size;
        return !c[COORD_W-1] && (c[COORD_W-2:0] < (COORD_W-1)'(lim));
    endfunction

    assign is_read    = item_reg.command[1];
    assign in_volume  = axis_ok(item_reg.coord_x, size_x_reg)
                      && axis_ok(item_reg.coord_y, size_y_reg)
                      && axis_ok(item_reg.coord_z, size_z_reg);
    assign voxel_addr = {item_reg.coord_z[AXIS_BITS-1:0], item_reg.coord_y[AXIS_BITS-1:0],
                         item_reg.coord_x[AXIS_BITS-1:0]};
    assign last       = count_reg - COUNT_W'(1);
    assign idx        = map_q - COUNT_W'(1);
    assign pos_ok     = {1'b0, item_reg.position} < count_reg;
    assign del_hit    = (map_q != '0) && (map_q <= count_reg);
    assign list_raddr = is_read ? item_reg.position : last[ADDR_W-1:0];

    assign dp_status.clear_last = (clr_addr_reg == {ADDR_W{1'b1}});
    assign dp_status.need_fix   = !is_read && in_volume && (item_reg.command == CMD_DELETE)
                                  && del_hit && (idx != last);

    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        map_we      = 1'b0;
        map_waddr   = voxel_addr;
        map_wdata   = '0;
        list_we     = 1'b0;
        list_waddr  = count_reg[ADDR_W-1:0];
        list_wdata  = voxel_addr;
        priority if (ctrl_cmd.clear_step)
        begin
            map_we    = 1'b1;
            map_waddr = clr_addr_reg;
        end
        else if (ctrl_cmd.fix)
        begin
            map_we    = 1'b1;
            map_waddr = fix_addr_reg;
            map_wdata = fix_data_reg;
        end
        else if (ctrl_cmd.exec)
        begin
            if (is_read)
            begin
                if (pos_ok)
                begin
                    result_next.status = STS_READ_OK;
                    result_next.out_x  = OUT_W'(list_q[AXIS_BITS-1:0]);
                    result_next.out_y  = OUT_W'(list_q[2*AXIS_BITS-1:AXIS_BITS]);
                    result_next.out_z  = OUT_W'(list_q[3*AXIS_BITS-1:2*AXIS_BITS]);
                end
                else
                begin
                    result_next.status = STS_BEYOND;
                end
            end
            else if (!in_volume)
            begin
                result_next.status = STS_OUTSIDE;
            end
            else if (item_reg.command == CMD_ADD)
            begin
                if (map_q != '0)
                begin
                    result_next.status = STS_PRESENT;
                end
                else
                begin
                    result_next.status = STS_ADDED;
                    count_next         = count_reg + COUNT_W'(1);
                    list_we            = 1'b1;
                    map_we             = 1'b1;
                    map_wdata          = count_next;
                end
            end
            else if (del_hit)
            begin
                result_next.status = STS_REMOVED;
                count_next         = last;
                map_we             = 1'b1;
                list_waddr         = idx[ADDR_W-1:0];
                list_wdata         = list_q;
                list_we            = (idx != last);
            end
            else
            begin
                result_next.status = STS_ABSENT;
            end
            result_next.member_count = count_next;
        end
        else
        begin
            map_we = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (ctrl_cmd.lookup)
        begin
            map_q <= map_mem[voxel_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (ctrl_cmd.lookup)
        begin
            list_q <= list_mem[list_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            item_reg <= item;
        end
        if (ctrl_cmd.exec)
        begin
            result_reg   <= result_next;
            fix_addr_reg <= list_q;
            fix_data_reg <= map_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg   <= AXIS_SPAN;
            size_y_reg   <= AXIS_SPAN;
            size_z_reg   <= AXIS_SPAN;
            count_reg    <= '0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg  <= ctrl_cmd.finish;
            count_reg <= count_next;
            if (ctrl_cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SIZE_X: size_x_reg <= cfg_data;
                    REG_SIZE_Y: size_y_reg <= cfg_data;
                    REG_SIZE_Z: size_z_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sv/voxel_sparse_set_core.sv
`timescale 1ns / 1ps
// The result strobe follows the lookup and execute states; a delete that moves the
// last list entry into the freed slot adds a fix-up state (second map write).
// A new transaction is taken only from idle, after the lookup, update and fix-up
// write of the synchronous map memory for the previous one are through.
// Reset clears the map with one word per cycle: busy stays high until all of it is clear.
// Results are strobed for one cycle; the receiver cannot stall.

module voxel_sparse_set_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  vss_pkg::item_t              item,
    output logic                        busy,
    output logic                        done,
    output vss_pkg::result_t            result,
    input  logic                        cfg_we,
    input  logic [vss_pkg::IDX_W-1:0]   cfg_index,
    input  logic [vss_pkg::SIZE_W-1:0]  cfg_data
);
    import vss_pkg::*;

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    vss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd),
        .busy      (busy)
    );

    vss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_cmd  (ctrl_cmd),
        .dp_status (dp_status),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

### test/tb_voxel_sparse_set_core.sv
`timescale 1ns / 1ps

module tb_voxel_sparse_set_core;

    import vss_pkg::*;

    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 8;

    // Tracks the set as the block should hold it and queues one response per command.
    class voxel_set_scoreboard;
        bit [COUNT_W-1:0] slot_of [DEPTH];
        bit [ADDR_W-1:0]  member_at [DEPTH];
        bit [COUNT_W-1:0] members;
        bit [SIZE_W-1:0]  extent [3];
        result_t          awaited [$];
        int               mismatches;

        function new();
            members    = '0;
            mismatches = 0;
            foreach (extent[i])
            begin
                extent[i] = 7'd64;
            end
        endfunction

        function void set_extent(int axis, logic [SIZE_W-1:0] value);
            extent[axis] = value;
        endfunction

        function bit axis_hit(logic signed [COORD_W-1:0] c, bit [SIZE_W-1:0] ext);
            bit [SIZE_W-1:0] lim;
            int              cv;
            lim = (ext > AXIS_SPAN) ? AXIS_SPAN : ext;
            cv  = c;
            return (cv >= 0) && (cv < int'(lim));
        endfunction

        function void note_command(item_t it);
            result_t          r;
            bit [ADDR_W-1:0]  vox;
            bit [ADDR_W-1:0]  moved;
            bit [COUNT_W-1:0] slot;
            r = '0;
            if (it.command[1])
            begin
                if (COUNT_W'(it.position) < members)
                begin
                    vox      = member_at[it.position];
                    r.out_x  = vox[AXIS_BITS-1:0];
                    r.out_y  = vox[2*AXIS_BITS-1:AXIS_BITS];
                    r.out_z  = vox[ADDR_W-1:2*AXIS_BITS];
                    r.status = STS_READ_OK;
                end
                else
                begin
                    r.status = STS_BEYOND;
                end
            end
            else if (!(axis_hit(it.coord_x, extent[0]) && axis_hit(it.coord_y, extent[1])
                       && axis_hit(it.coord_z, extent[2])))
            begin
                r.status = STS_OUTSIDE;
            end
            else
            begin
                vox = {it.coord_z[AXIS_BITS-1:0], it.coord_y[AXIS_BITS-1:0],
                       it.coord_x[AXIS_BITS-1:0]};
                slot = slot_of[vox];
                if (it.command == CMD_ADD)
                begin
                    if (slot != 0)
                    begin
                        r.status = STS_PRESENT;
                    end
                    else
                    begin
                        member_at[members[ADDR_W-1:0]] = vox;
                        members      = members + 1'b1;
                        slot_of[vox] = members;
                        r.status     = STS_ADDED;
                    end
                end
                else if (slot == 0 || slot > members)
                begin
                    r.status = STS_ABSENT;
                end
                else
                begin
                    slot_of[vox] = '0;
                    // The last entry fills the hole unless the hole is the last entry.
                    if (slot != members)
                    begin
                        moved                           = member_at[ADDR_W'(members - 1'b1)];
                        member_at[ADDR_W'(slot - 1'b1)] = moved;
                        slot_of[moved]                  = slot;
                    end
                    members  = members - 1'b1;
                    r.status = STS_REMOVED;
                end
            end
            r.member_count = members;
            awaited = {awaited, r};
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: %s: expected sts=%0d x=%0d y=%0d z=%0d cnt=%0d",
                         $realtime, what, want.status, want.out_x, want.out_y, want.out_z,
                         want.member_count);
                $display("%0t: %s: got      sts=%0d x=%0d y=%0d z=%0d cnt=%0d",
                         $realtime, what, got.status, got.out_x, got.out_y, got.out_z,
                         got.member_count);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected response", '0, got);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.out_x !== want.out_x
                || got.out_y !== want.out_y || got.out_z !== want.out_z
                || got.member_count !== want.member_count)
            begin
                report("response mismatch", want, got);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    item_t               item;
    logic                busy;
    logic                done;
    result_t             result;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [SIZE_W-1:0]   cfg_data;

    voxel_set_scoreboard sb;
    int                  cycle_count;
    int                  burst_left;

    voxel_sparse_set_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_voxel_sparse_set_core NOT OK");
            $finish;
        end
    end

    function automatic item_t compose_item(logic [1:0] cmd, int x, int y, int z, int pos);
        item_t it;
        it.command  = cmd;
        it.coord_x  = COORD_W'(x);
        it.coord_y  = COORD_W'(y);
        it.coord_z  = COORD_W'(z);
        it.position = ADDR_W'(pos);
        return it;
    endfunction

    // Mostly well-formed commands inside a small cube so that adds and deletes collide.
    function automatic item_t random_item(int span);
        item_t           it;
        int              pick;
        bit [ADDR_W-1:0] vox;
        pick = $urandom_range(0, 99);
        it   = compose_item(CMD_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                            $urandom_range(0, span - 1), $urandom_range(0, DEPTH - 1));
        if (pick < 40)
        begin
            it.command = CMD_ADD;
        end
        else if (pick < 55)
        begin
            it.command = CMD_DELETE;
        end
        else if (pick < 65 && sb.members != 0)
        begin
            vox        = sb.member_at[ADDR_W'($urandom_range(0, int'(sb.members) - 1))];
            it.command = CMD_DELETE;
            it.coord_x = COORD_W'(vox[AXIS_BITS-1:0]);
            it.coord_y = COORD_W'(vox[2*AXIS_BITS-1:AXIS_BITS]);
            it.coord_z = COORD_W'(vox[ADDR_W-1:2*AXIS_BITS]);
        end
        else if (pick < 85)
        begin
            it.command  = ($urandom_range(0, 4) == 0) ? CMD_SPARE : CMD_READ;
            it.position = ADDR_W'($urandom_range(0, int'(sb.members) + 2));
        end
        else
        begin
            it.command  = 2'($urandom);
            it.coord_x  = COORD_W'($urandom);
            it.coord_y  = COORD_W'($urandom);
            it.coord_z  = COORD_W'($urandom);
            it.position = ADDR_W'($urandom);
        end
        return it;
    endfunction

    task automatic send_item(item_t it);
        @(negedge clk);
        start = 1'b1;
        item  = it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_command(it);
    endtask

    // Sender works in bursts; a gap of zero keeps start high across the burst boundary.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
            end
            if (gap != 0)
            begin
                @(negedge clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.awaited.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] index, logic [SIZE_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        sb.set_extent(int'(index), value);
    endtask

    task automatic run_phase(int sx, int sy, int sz, int span, int count);
        drain();
        write_reg(REG_SIZE_X, SIZE_W'(sx));
        write_reg(REG_SIZE_Y, SIZE_W'(sy));
        write_reg(REG_SIZE_Z, SIZE_W'(sz));
        @(negedge clk);
        cfg_we = 1'b0;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            // Let everything in flight come back once in the middle of each phase.
            if (i == count / 2)
            begin
                drain();
            end
            pace_sender();
            send_item(random_item(span));
        end
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_SIZE_X;
        cfg_data    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // The map is cleared word by word after reset.
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end

        // Directed part with the reset volume of 64 on every axis.
        send_item(compose_item(CMD_ADD, 0, 0, 0, 0));
        send_item(compose_item(CMD_ADD, 63, 63, 63, 0));
        send_item(compose_item(CMD_ADD, 0, 0, 0, 0));
        send_item(compose_item(CMD_ADD, 64, 0, 0, 0));
        send_item(compose_item(CMD_ADD, -1, 5, 5, 0));
        send_item(compose_item(CMD_ADD, -32768, 32767, 0, 0));
        send_item(compose_item(CMD_ADD, 1, 2, 3, 0));
        send_item(compose_item(CMD_READ, 0, 0, 0, 0));
        send_item(compose_item(CMD_READ, 0, 0, 0, 2));
        send_item(compose_item(CMD_READ, 0, 0, 0, 3));
        send_item(compose_item(CMD_READ, -1, -1, -1, DEPTH - 1));
        send_item(compose_item(CMD_SPARE, 0, 0, 0, 1));
        send_item(compose_item(CMD_DELETE, 0, 0, 0, 0));
        send_item(compose_item(CMD_DELETE, 0, 0, 0, 0));
        send_item(compose_item(CMD_READ, 0, 0, 0, 0));
        send_item(compose_item(CMD_DELETE, 63, 63, 63, 0));
        send_item(compose_item(CMD_DELETE, 5, 0, 70, 0));
        send_item(compose_item(CMD_DELETE, 32767, -32768, 1, 0));
        send_item(compose_item(CMD_ADD, 32, 16, 8, 0));
        send_item(compose_item(CMD_READ, 0, 0, 0, 1));
        send_item(compose_item(CMD_SPARE, 0, 0, 0, 2));

        // Dense cube, sizes above it, shrunken volume, empty axes, one voxel, full volume.
        run_phase(4, 4, 4, 5, 100);
        run_phase(127, 127, 127, 70, 60);
        run_phase(2, 3, 1, 5, 60);
        run_phase(0, 64, 64, 4, 30);
        run_phase(64, 0, 0, 4, 20);
        run_phase(1, 1, 1, 2, 30);
        run_phase(64, 64, 64, 64, 100);
        drain();

        if (sb.mismatches == 0 && sb.awaited.size() == 0)
        begin
            $display("tb_voxel_sparse_set_core OK");
        end
        else
        begin
            $display("tb_voxel_sparse_set_core NOT OK");
        end
        $finish;
    end

endmodule
